/* sv/sampled_action_waypoint_follower_defines.svh */
`ifndef SAMPLED_ACTION_WAYPOINT_FOLLOWER_DEFINES_SVH
`define SAMPLED_ACTION_WAYPOINT_FOLLOWER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SAWF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SAWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/swaw_pkg.sv */
package swaw_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int TURN_SAMPLES  = 44;

    localparam int W_EDGE       = 11633;
    localparam int W_SPAN       = 4 * W_EDGE;
    localparam int PI_Q16       = 205887;
    localparam int TWO_PI_Q16   = 411775;
    localparam int HALF_PI_Q16  = 102944;
    localparam int CORDIC_K     = 652032874;
    localparam int CORDIC_STEPS = 17;

    localparam int RESET_REACH = 655;
    localparam int RESET_SPEED = 6554;

    localparam int ANG_W  = 21;
    localparam int TRIG_W = 34;
    localparam int ERR_W  = 34;

    localparam logic [1:0] CFG_REACH = 2'd0;
    localparam logic [1:0] CFG_SPEED = 2'd1;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_LOAD = 10'b00_0000_0010,
        ST_SQX  = 10'b00_0000_0100,
        ST_SQY  = 10'b00_0000_1000,
        ST_SUM  = 10'b00_0001_0000,
        ST_PREP = 10'b00_0010_0000,
        ST_ROT  = 10'b00_0100_0000,
        ST_MULC = 10'b00_1000_0000,
        ST_MULS = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } t_state;

    // Arctangent of 2^-i in Q16.16
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 21'sd51472;
            5'd1:    a = 21'sd30386;
            5'd2:    a = 21'sd16055;
            5'd3:    a = 21'sd8150;
            5'd4:    a = 21'sd4091;
            5'd5:    a = 21'sd2047;
            5'd6:    a = 21'sd1024;
            5'd7:    a = 21'sd512;
            5'd8:    a = 21'sd256;
            5'd9:    a = 21'sd128;
            5'd10:   a = 21'sd64;
            5'd11:   a = 21'sd32;
            5'd12:   a = 21'sd16;
            5'd13:   a = 21'sd8;
            5'd14:   a = 21'sd4;
            5'd15:   a = 21'sd2;
            5'd16:   a = 21'sd1;
            default: a = 21'sd0;
        endcase
        return a;
    endfunction

    // Square with saturation once the magnitude exceeds 32 bits
    function automatic logic [63:0] sat_sq(input logic signed [ERR_W-1:0] d);
        logic [ERR_W-1:0] a;
        a = d[ERR_W-1] ? ERR_W'(-d) : ERR_W'(d);
        if (a[ERR_W-1:32] != '0) begin
            return {64{1'b1}};
        end
        return 64'(a[31:0]) * 64'(a[31:0]);
    endfunction

endpackage

/* sv/swaw_ram.sv */
module swaw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/swaw_cordic.sv */
module swaw_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [swaw_pkg::ANG_W-1:0]   i_theta,
    output logic                                o_done,
    output swaw_pkg::t_trig                     o_trig
);

    localparam int AW = swaw_pkg::ANG_W;
    localparam int TW = swaw_pkg::TRIG_W;
    localparam logic signed [AW-1:0] PI      = AW'(swaw_pkg::PI_Q16);
    localparam logic signed [AW-1:0] TWO_PI  = AW'(swaw_pkg::TWO_PI_Q16);
    localparam logic signed [AW-1:0] HALF_PI = AW'(swaw_pkg::HALF_PI_Q16);
    localparam logic [4:0] LAST_STEP = 5'(swaw_pkg::CORDIC_STEPS - 1);

    logic                 r_busy, r_done;
    logic [4:0]           r_step;
    logic signed [TW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic                 r_flip;

    logic signed [AW-1:0] wrapped, folded;
    logic                 flip;
    logic signed [TW-1:0] xs, ys;
    logic signed [AW-1:0] at;

    // One wrap is enough for the input range; then fold into the right half plane
    always_comb begin
        wrapped = i_theta;
        if (i_theta > PI) begin
            wrapped = i_theta - TWO_PI;
        end else if (i_theta < -PI) begin
            wrapped = i_theta + TWO_PI;
        end
        folded = wrapped;
        flip   = 1'b0;
        if (wrapped > HALF_PI) begin
            folded = wrapped - PI;
            flip   = 1'b1;
        end else if (wrapped < -HALF_PI) begin
            folded = wrapped + PI;
            flip   = 1'b1;
        end
    end

    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;
    assign at = swaw_pkg::atan_q16(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= TW'(swaw_pkg::CORDIC_K);
                r_y    <= '0;
                r_z    <= folded;
                r_flip <= flip;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_step <= r_step + 5'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_trig.cos_v = r_flip ? -r_x : r_x;
    assign o_trig.sin_v = r_flip ? -r_y : r_y;

endmodule

/* sv/sampled_action_waypoint_follower.sv */
// Channel  Direction  Handshake                    Payload
// in       slave      i_in_valid / o_in_stall      operation, path_first, pos_x, pos_y, pose_yaw
// out      master     o_out_valid / i_out_stall    action_index, speeds, stopped, waypoint_index
// cfg      slave      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An append completes in the idle state, so appends can follow back to back. A tick with no
// waypoint left goes straight to the finish state. A live tick loads the goal, scores it, then
// sweeps 2*TURN_SAMPLES candidate actions, each through the serial 17-step CORDIC rotator.
// Synchronous active-low reset clears count and index; the store needs no clearing.
// A finished result waits in the output register while i_out_stall is high.
`include "sampled_action_waypoint_follower_defines.svh"

module sampled_action_waypoint_follower #(
    parameter int MAX_WAYPOINTS = swaw_pkg::MAX_WAYPOINTS,
    parameter int TURN_SAMPLES  = swaw_pkg::TURN_SAMPLES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic               i_path_first,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [14:0] i_pose_yaw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [6:0]         o_action_index,
    output logic signed [16:0] o_linear_speed,
    output logic signed [14:0] o_angular_speed,
    output logic               o_stopped,
    output logic [8:0]         o_waypoint_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int CW  = $clog2(MAX_WAYPOINTS + 1);
    localparam int AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int N2  = 2 * (TURN_SAMPLES - 1);
    localparam int Q_STEP = swaw_pkg::W_SPAN / N2;
    localparam int R_STEP = swaw_pkg::W_SPAN % N2;
    localparam int RW  = $clog2(2 * N2);
    localparam int EW  = swaw_pkg::ERR_W;
    localparam int GW  = swaw_pkg::ANG_W;
    localparam logic [6:0] K_HALF = 7'(TURN_SAMPLES);
    localparam logic [6:0] K_LAST = 7'(2 * TURN_SAMPLES - 1);

    swaw_pkg::t_state r_state;

    logic [31:0]        r_reach;
    logic [15:0]        r_speed;
    logic [CW-1:0]      r_count, r_index;
    logic signed [31:0] r_px, r_py, r_gx, r_gy;
    logic signed [14:0] r_yaw;
    logic signed [EW-1:0] r_ex, r_ey;
    logic [63:0]        r_sqx, r_sqy, r_best_cost;
    logic               r_cand, r_stop;
    logic [6:0]         r_k, r_best_k;
    logic [14:0]        r_q;
    logic [RW-1:0]      r_r;
    logic signed [14:0] r_best_w;
    logic signed [16:0] r_best_v;

    logic               r_ov, r_o_stop;
    logic [6:0]         r_o_k;
    logic signed [16:0] r_o_v;
    logic signed [14:0] r_o_w;
    logic [8:0]         r_o_idx;

    logic               in_acc, cfg_acc, out_free, out_load;
    logic [CW-1:0]      eff_count;
    logic               wr_en, rd_en;
    logic [63:0]        rd_data;
    logic               cord_start, cord_done;
    swaw_pkg::t_trig    trig;
    logic signed [14:0] w_cur;
    logic signed [16:0] v_cur;
    logic signed [GW-1:0] theta;
    logic [64:0]        sum;
    logic [63:0]        cost;
    logic signed [51:0] prod_c, prod_s;
    logic signed [51:0] move_c, move_s;
    logic [RW-1:0]      step_sum;
    logic [CW+8:0]      idx_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_ov || !i_out_stall;
    assign out_load = (r_state == swaw_pkg::ST_FIN) && out_free;

    assign eff_count = i_path_first ? '0 : r_count;
    assign wr_en = in_acc && (i_operation == swaw_pkg::OP_APPEND)
                   && (eff_count < CW'(MAX_WAYPOINTS));
    assign rd_en = in_acc && (i_operation == swaw_pkg::OP_TICK);

    swaw_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (eff_count[AW-1:0]),
        .i_wr_data ({i_pos_y, i_pos_x}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_index[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign w_cur = 15'(r_q) - 15'(swaw_pkg::W_EDGE);
    assign v_cur = (r_k < K_HALF) ? $signed({1'b0, r_speed}) : -$signed({1'b0, r_speed});
    assign theta = (GW'(r_yaw) <<< 4) + (GW'(w_cur) <<< 3);
    assign cord_start = (r_state == swaw_pkg::ST_PREP);

    swaw_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_theta (theta),
        .o_done  (cord_done),
        .o_trig  (trig)
    );

    // Displacement rounds to nearest, ties up
    assign prod_c = 52'(v_cur) * 52'(trig.cos_v) + (52'sd1 <<< 30);
    assign prod_s = 52'(v_cur) * 52'(trig.sin_v) + (52'sd1 <<< 30);
    assign move_c = prod_c >>> 31;
    assign move_s = prod_s >>> 31;

    assign sum      = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign cost     = sum[64] ? {64{1'b1}} : sum[63:0];
    assign step_sum = r_r + RW'(R_STEP);
    assign idx_ext  = {9'b0, r_index} + (CW+9)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach <= 32'(swaw_pkg::RESET_REACH);
            r_speed <= 16'(swaw_pkg::RESET_SPEED);
        end else if (cfg_acc) begin
            case (i_cfg_index)
                swaw_pkg::CFG_REACH: r_reach <= i_cfg_data;
                swaw_pkg::CFG_SPEED: r_speed <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swaw_pkg::ST_IDLE;
            r_count <= '0;
            r_index <= '0;
        end else begin
            case (r_state)
                swaw_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == swaw_pkg::OP_APPEND) begin
                            if (i_path_first) begin
                                r_index <= '0;
                            end
                            if (wr_en) begin
                                r_count <= eff_count + CW'(1);
                            end
                        end else begin
                            r_px  <= i_pos_x;
                            r_py  <= i_pos_y;
                            r_yaw <= i_pose_yaw;
                            r_stop <= (r_index >= r_count);
                            r_state <= (r_index >= r_count) ? swaw_pkg::ST_FIN
                                                            : swaw_pkg::ST_LOAD;
                        end
                    end
                end
                swaw_pkg::ST_LOAD: begin
                    r_gx   <= rd_data[31:0];
                    r_gy   <= rd_data[63:32];
                    r_ex   <= EW'($signed(rd_data[31:0])) - EW'(r_px);
                    r_ey   <= EW'($signed(rd_data[63:32])) - EW'(r_py);
                    r_cand <= 1'b0;
                    r_state <= swaw_pkg::ST_SQX;
                end
                swaw_pkg::ST_SQX: begin
                    r_sqx   <= swaw_pkg::sat_sq(r_ex);
                    r_state <= swaw_pkg::ST_SQY;
                end
                swaw_pkg::ST_SQY: begin
                    r_sqy   <= swaw_pkg::sat_sq(r_ey);
                    r_state <= swaw_pkg::ST_SUM;
                end
                swaw_pkg::ST_SUM: begin
                    if (!r_cand) begin
                        // Arrival advances the index; the goal stays for this tick
                        if (cost < {16'b0, r_reach, 16'b0}) begin
                            r_index <= idx_ext[CW-1:0];
                        end
                        r_cand  <= 1'b1;
                        r_k     <= '0;
                        r_q     <= '0;
                        r_r     <= RW'(TURN_SAMPLES - 1);
                        r_state <= swaw_pkg::ST_PREP;
                    end else begin
                        if (r_k == '0 || cost < r_best_cost) begin
                            r_best_cost <= cost;
                            r_best_k    <= r_k;
                            r_best_w    <= w_cur;
                            r_best_v    <= v_cur;
                        end
                        if (r_k == K_LAST) begin
                            r_state <= swaw_pkg::ST_FIN;
                        end else begin
                            r_k <= r_k + 7'd1;
                            // Restart the turn rate sweep for the reverse half
                            if (r_k == K_HALF - 7'd1) begin
                                r_q <= '0;
                                r_r <= RW'(TURN_SAMPLES - 1);
                            end else if (step_sum >= RW'(N2)) begin
                                r_q <= r_q + 15'(Q_STEP + 1);
                                r_r <= step_sum - RW'(N2);
                            end else begin
                                r_q <= r_q + 15'(Q_STEP);
                                r_r <= step_sum;
                            end
                            r_state <= swaw_pkg::ST_PREP;
                        end
                    end
                end
                swaw_pkg::ST_PREP: begin
                    r_state <= swaw_pkg::ST_ROT;
                end
                swaw_pkg::ST_ROT: begin
                    if (cord_done) begin
                        r_state <= swaw_pkg::ST_MULC;
                    end
                end
                swaw_pkg::ST_MULC: begin
                    r_ex    <= EW'(r_px) + EW'(move_c) - EW'(r_gx);
                    r_state <= swaw_pkg::ST_MULS;
                end
                swaw_pkg::ST_MULS: begin
                    r_ey    <= EW'(r_py) + EW'(move_s) - EW'(r_gy);
                    r_state <= swaw_pkg::ST_SQX;
                end
                swaw_pkg::ST_FIN: begin
                    if (out_free) begin
                        r_state <= swaw_pkg::ST_IDLE;
                    end
                end
                default: r_state <= swaw_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_stop <= r_stop;
            r_o_k    <= r_stop ? 7'd0 : r_best_k;
            r_o_v    <= r_stop ? 17'sd0 : r_best_v;
            r_o_w    <= r_stop ? 15'sd0 : r_best_w;
            r_o_idx  <= idx_ext[8:0] - 9'd1;
        end
    end

    assign o_in_stall       = (r_state != swaw_pkg::ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_ov;
    assign o_action_index   = r_o_k;
    assign o_linear_speed   = r_o_v;
    assign o_angular_speed  = r_o_w;
    assign o_stopped        = r_o_stop;
    assign o_waypoint_index = r_o_idx;

    `SAWF_ASSERT_NOW(a_index_in_list, 1'b1, r_index <= r_count, "index passed waypoint count")
    `SAWF_ASSERT_NOW(a_cordic_done_in_rot, cord_done, r_state == swaw_pkg::ST_ROT, "stray CORDIC done")
    `SAWF_ASSERT_NOW(a_stop_zero, o_out_valid && o_stopped, o_linear_speed == 17'sd0 && o_angular_speed == 15'sd0 && o_action_index == 7'd0, "stopped result carries motion")
    `SAWF_ASSERT_NEXT(a_tick_leaves_idle, in_acc && i_operation == swaw_pkg::OP_TICK, r_state != swaw_pkg::ST_IDLE, "tick not started")

endmodule
